// File: design/pacs_pkg.sv
`default_nettype none

package pacs_pkg;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OP_W     = 7;
  localparam int unsigned SHAMT_W  = 3;

  // input tdata width: 18 field bits padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 24;
  // result tdata width: 45 field bits padded to whole bytes
  localparam int unsigned OUT_TDATA_W = 48;

  // configuration register indexes
  localparam logic CFG_OPERAND   = 1'b0;
  localparam logic CFG_CODE_PAGE = 1'b1;

  // opcodes, low 7 bits of the instruction byte
  localparam logic [OP_W-1:0] OP_NOP      = 7'h00;
  localparam logic [OP_W-1:0] OP_HALT     = 7'h01;
  localparam logic [OP_W-1:0] OP_IN       = 7'h02;
  localparam logic [OP_W-1:0] OP_OUT      = 7'h03;
  localparam logic [OP_W-1:0] OP_SHIFT    = 7'h04;
  localparam logic [OP_W-1:0] OP_BIT0     = 7'h05;
  localparam logic [OP_W-1:0] OP_ROR      = 7'h06;
  localparam logic [OP_W-1:0] OP_ROR1     = 7'h07;
  localparam logic [OP_W-1:0] OP_CLR_HI   = 7'h08;
  localparam logic [OP_W-1:0] OP_CLR_CY   = 7'h09;
  localparam logic [OP_W-1:0] OP_CLR_USR  = 7'h0a;
  localparam logic [OP_W-1:0] OP_CLR_FILL = 7'h0b;
  localparam logic [OP_W-1:0] OP_TGL_PRED = 7'h0c;
  localparam logic [OP_W-1:0] OP_SET_CY   = 7'h0d;
  localparam logic [OP_W-1:0] OP_SET_USR  = 7'h0e;
  localparam logic [OP_W-1:0] OP_SET_FILL = 7'h0f;

  // status codes
  localparam logic [STATUS_W-1:0] ST_RUN     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HALT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ILLEGAL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_SH  = 2'd3;

  // flag bit positions
  localparam int unsigned FLAG_PRED  = 0;
  localparam int unsigned FLAG_CARRY = 1;
  localparam int unsigned FLAG_USER  = 2;
  localparam int unsigned FLAG_FILL  = 3;

  // port numbers held in the operand register
  localparam logic [DATA_W-1:0] PORT_ZERO = 8'd0;
  localparam logic [DATA_W-1:0] PORT_ONE  = 8'd1;
  localparam logic [DATA_W-1:0] PORT_TWO  = 8'd2;

  typedef struct packed {
    logic                in_accept;
    logic                in_available;
    logic [DATA_W-1:0]   in_byte;
    logic [DATA_W-1:0]   instruction;
  } item_t;

  // first field in the highest bits
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                executed;
    logic [DATA_W-1:0]   out_byte;
    logic                out_port;
    logic                out_valid;
    logic [DATA_W-1:0]   flag_value;
    logic [DATA_W-1:0]   accumulator_value;
    logic [ADDR_W-1:0]   next_fetch_address;
  } result_t;

endpackage

`default_nettype wire

// File: design/predicated_accumulator_cpu_step.sv
`default_nettype none

// predicated accumulator step engine
//
// in_* channel: one transaction carries one fetched instruction byte together with
//   the port-zero input byte and its availability flag and the output-sink accept
//   flag; the engine executes it against its accumulator, flags, program counter
//   and stopped mark
// out_* channel: one transaction per accepted instruction, holding the next fetch
//   address, accumulator, flags, output-port request, executed bit and status
// cfg_* port: write-only, index 0 is the signed operand register, index 1 the
//   code page; write only while no transaction is in flight
// latency: the result appears on out_tvalid the cycle after the input transaction
// throughput: one instruction per cycle unless stalled; the whole step is one
//   8-bit shift or rotate plus flag update between state and result registers
// stall: the result register holds while out_tready is low, and in_tready drops
//   only while a result is waiting and the receiver is stalling
// reset: accumulator, flags, program counter and stopped mark clear, operand
//   register clears, code page goes to 0xff, and the result register empties
// once halted or faulted every step reports status halted and changes nothing
module predicated_accumulator_cpu_step_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // instruction, in_byte, in_available, out_accept, 6 zero bits
  input  wire logic [pacs_pkg::IN_TDATA_W-1:0]  in_tdata,
  // result stream
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // next_fetch_address, accumulator_value, flag_value, out_valid, out_port,
  // out_byte, executed, status, 3 zero bits
  output      logic [pacs_pkg::OUT_TDATA_W-1:0] out_tdata,
  // configuration writes
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [pacs_pkg::DATA_W-1:0]      cfg_wdata
);

  localparam int unsigned PAD_W = pacs_pkg::OUT_TDATA_W - $bits(pacs_pkg::result_t);

  // architectural state
  logic [pacs_pkg::DATA_W-1:0] acc_r,   acc_nxt;
  logic [pacs_pkg::DATA_W-1:0] flags_r, flags_nxt;
  logic [pacs_pkg::DATA_W-1:0] pc_r,    pc_nxt;
  logic                        stopped_r, stopped_nxt;

  // configuration registers
  logic [pacs_pkg::DATA_W-1:0] opnd_r;
  logic [pacs_pkg::DATA_W-1:0] page_r;

  // result register
  logic                        out_vld_r;
  pacs_pkg::result_t           res_r, res_nxt;

  pacs_pkg::item_t             item;
  logic                        in_fire;

  assign item      = pacs_pkg::item_t'(in_tdata[$bits(pacs_pkg::item_t)-1:0]);
  assign in_tready = !out_vld_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{PAD_W{1'b0}}, res_r};

  // one instruction step
  always_comb begin
    logic [pacs_pkg::OP_W-1:0]    op;
    logic [pacs_pkg::DATA_W-1:0]  a;
    logic [pacs_pkg::DATA_W-1:0]  neg_opnd;
    logic [pacs_pkg::DATA_W-1:0]  fill;
    logic [pacs_pkg::SHAMT_W-1:0] n_r;
    logic [pacs_pkg::SHAMT_W-1:0] n_l;
    logic [2*pacs_pkg::DATA_W-1:0] wide_r;
    logic [2*pacs_pkg::DATA_W-1:0] wide_l;
    logic [2*pacs_pkg::DATA_W-1:0] wide_rot;
    logic                         sh_right_ok;
    logic                         sh_left_ok;
    logic                         ror_ok;
    logic                         executed;
    logic                         out_v;
    logic                         out_p;
    logic [pacs_pkg::DATA_W-1:0]  out_b;
    logic [pacs_pkg::STATUS_W-1:0] status;

    op        = item.instruction[pacs_pkg::OP_W-1:0];
    a         = acc_r;
    neg_opnd  = 8'd0 - opnd_r;
    fill      = {pacs_pkg::DATA_W{flags_r[pacs_pkg::FLAG_FILL]}};
    n_r       = opnd_r[pacs_pkg::SHAMT_W-1:0];
    n_l       = neg_opnd[pacs_pkg::SHAMT_W-1:0];
    // right by 1..7 or left by 1..7 (operand 0xf9..0xff)
    sh_right_ok = (opnd_r[7:3] == 5'd0) && (n_r != 3'd0);
    sh_left_ok  = (opnd_r[7:3] == 5'h1f) && (n_l != 3'd0);
    ror_ok      = sh_right_ok;
    wide_r    = {fill, a} >> n_r;
    wide_l    = {a, fill} << n_l;
    wide_rot  = {a, a} >> n_r;

    acc_nxt     = acc_r;
    flags_nxt   = flags_r;
    pc_nxt      = pc_r;
    stopped_nxt = stopped_r;
    executed    = 1'b0;
    out_v       = 1'b0;
    out_p       = 1'b0;
    out_b       = '0;
    status      = pacs_pkg::ST_RUN;

    if (stopped_r) begin
      status = pacs_pkg::ST_HALT;
    end else begin
      pc_nxt = pc_r + 8'd1;
      // predicate: bit 7 must match flag bit 0
      if (item.instruction[7] == flags_r[pacs_pkg::FLAG_PRED]) begin
        executed = 1'b1;
        case (op)
          pacs_pkg::OP_NOP: begin
          end
          pacs_pkg::OP_HALT: begin
            stopped_nxt = 1'b1;
            status      = pacs_pkg::ST_HALT;
          end
          pacs_pkg::OP_IN: begin
            if (opnd_r != pacs_pkg::PORT_ZERO) begin
              acc_nxt = '0;
              flags_nxt[pacs_pkg::FLAG_CARRY] = 1'b1;
            end else if (item.in_available) begin
              acc_nxt = item.in_byte;
              flags_nxt[pacs_pkg::FLAG_CARRY] = 1'b0;
            end else begin
              acc_nxt = '1;
              flags_nxt[pacs_pkg::FLAG_CARRY] = 1'b1;
            end
          end
          pacs_pkg::OP_OUT: begin
            if ((opnd_r == pacs_pkg::PORT_ONE || opnd_r == pacs_pkg::PORT_TWO)
                && item.in_accept) begin
              out_v = 1'b1;
              out_p = opnd_r[1];
              out_b = a;
              flags_nxt[pacs_pkg::FLAG_CARRY] = 1'b0;
            end else begin
              flags_nxt[pacs_pkg::FLAG_CARRY] = 1'b1;
            end
          end
          pacs_pkg::OP_SHIFT: begin
            if (sh_right_ok) begin
              flags_nxt[pacs_pkg::FLAG_CARRY] = a[n_r - 3'd1];
              acc_nxt = wide_r[pacs_pkg::DATA_W-1:0];
            end else if (sh_left_ok) begin
              flags_nxt[pacs_pkg::FLAG_CARRY] = a[3'd0 - n_l];
              acc_nxt = wide_l[2*pacs_pkg::DATA_W-1:pacs_pkg::DATA_W];
            end else begin
              executed    = 1'b0;
              stopped_nxt = 1'b1;
              status      = pacs_pkg::ST_BAD_SH;
            end
          end
          pacs_pkg::OP_BIT0: begin
            flags_nxt[pacs_pkg::FLAG_CARRY] = a[0];
          end
          pacs_pkg::OP_ROR: begin
            if (ror_ok) begin
              acc_nxt = wide_rot[pacs_pkg::DATA_W-1:0];
            end else begin
              executed    = 1'b0;
              stopped_nxt = 1'b1;
              status      = pacs_pkg::ST_BAD_SH;
            end
          end
          pacs_pkg::OP_ROR1: begin
            acc_nxt = {a[0], a[7:1]};
          end
          pacs_pkg::OP_CLR_HI: begin
            flags_nxt[7:4] = 4'd0;
          end
          pacs_pkg::OP_CLR_CY: begin
            flags_nxt[pacs_pkg::FLAG_CARRY] = 1'b0;
          end
          pacs_pkg::OP_CLR_USR: begin
            flags_nxt[pacs_pkg::FLAG_USER] = 1'b0;
          end
          pacs_pkg::OP_CLR_FILL: begin
            flags_nxt[pacs_pkg::FLAG_FILL] = 1'b0;
          end
          pacs_pkg::OP_TGL_PRED: begin
            flags_nxt[pacs_pkg::FLAG_PRED] = !flags_r[pacs_pkg::FLAG_PRED];
          end
          pacs_pkg::OP_SET_CY: begin
            flags_nxt[pacs_pkg::FLAG_CARRY] = 1'b1;
          end
          pacs_pkg::OP_SET_USR: begin
            flags_nxt[pacs_pkg::FLAG_USER] = 1'b1;
          end
          pacs_pkg::OP_SET_FILL: begin
            flags_nxt[pacs_pkg::FLAG_FILL] = 1'b1;
          end
          default: begin
            // unassigned opcode stops the machine
            executed    = 1'b0;
            stopped_nxt = 1'b1;
            status      = pacs_pkg::ST_ILLEGAL;
          end
        endcase
      end
    end

    res_nxt.next_fetch_address = {page_r, pc_nxt};
    res_nxt.accumulator_value  = acc_nxt;
    res_nxt.flag_value         = flags_nxt;
    res_nxt.out_valid          = out_v;
    res_nxt.out_port           = out_p;
    res_nxt.out_byte           = out_b;
    res_nxt.executed           = executed;
    res_nxt.status             = status;
  end

  // machine state moves only on an accepted instruction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      flags_r   <= '0;
      pc_r      <= '0;
      stopped_r <= 1'b0;
    end else if (in_fire) begin
      acc_r     <= acc_nxt;
      flags_r   <= flags_nxt;
      pc_r      <= pc_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opnd_r <= '0;
      page_r <= '1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pacs_pkg::CFG_OPERAND:   opnd_r <= cfg_wdata;
        pacs_pkg::CFG_CODE_PAGE: page_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // result register, holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_tready) begin
      out_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// File: verif/pacs_step_checker.sv
// watches the instruction and result channels, predicts every result and compares
module pacs_step_checker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  input  wire logic                              in_tready,
  // instruction, in_byte, in_available, out_accept, 6 zero bits
  input  wire logic [pacs_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                              out_tvalid,
  input  wire logic                              out_tready,
  // next_fetch_address, accumulator_value, flag_value, out_valid, out_port,
  // out_byte, executed, status, 3 zero bits
  input  wire logic [pacs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  wire logic                              cfg_wr_en,
  input  wire logic                              cfg_index,
  input  wire logic [pacs_pkg::DATA_W-1:0]       cfg_wdata,
  output int                                     fail_count,
  output int                                     pending_results
);

  // machine state as the block should hold it
  logic [pacs_pkg::DATA_W-1:0] acc_q;
  logic [pacs_pkg::DATA_W-1:0] flags_q;
  logic [pacs_pkg::DATA_W-1:0] pc_q;
  logic [pacs_pkg::DATA_W-1:0] operand_q;
  logic [pacs_pkg::DATA_W-1:0] page_q;
  logic                        stopped_q;

  pacs_pkg::result_t step_results_q[$];

  function automatic pacs_pkg::result_t step_machine(pacs_pkg::item_t it);
    pacs_pkg::result_t           r;
    logic [pacs_pkg::OP_W-1:0]   op;
    logic [pacs_pkg::DATA_W-1:0] a;
    logic [pacs_pkg::DATA_W-1:0] na;
    int                          sh;
    int                          n;
    r  = '0;
    op = it.instruction[pacs_pkg::OP_W-1:0];
    a  = acc_q;
    na = ~acc_q;
    sh = int'($signed(operand_q));
    n  = (sh < 0) ? -sh : sh;
    if (stopped_q) begin
      r.status = pacs_pkg::ST_HALT;
    end else begin
      pc_q = pc_q + 8'd1;
      if (it.instruction[pacs_pkg::DATA_W-1] == flags_q[pacs_pkg::FLAG_PRED]) begin
        r.executed = 1'b1;
        case (op)
          pacs_pkg::OP_NOP: ;
          pacs_pkg::OP_HALT: begin
            stopped_q = 1'b1;
            r.status  = pacs_pkg::ST_HALT;
          end
          pacs_pkg::OP_IN: begin
            if (operand_q != pacs_pkg::PORT_ZERO) begin
              acc_q = '0;
              flags_q[pacs_pkg::FLAG_CARRY] = 1'b1;
            end else if (it.in_available) begin
              acc_q = it.in_byte;
              flags_q[pacs_pkg::FLAG_CARRY] = 1'b0;
            end else begin
              acc_q = '1;
              flags_q[pacs_pkg::FLAG_CARRY] = 1'b1;
            end
          end
          pacs_pkg::OP_OUT: begin
            if ((operand_q == pacs_pkg::PORT_ONE || operand_q == pacs_pkg::PORT_TWO)
                && it.in_accept) begin
              r.out_valid = 1'b1;
              r.out_port  = (operand_q == pacs_pkg::PORT_TWO);
              r.out_byte  = a;
              flags_q[pacs_pkg::FLAG_CARRY] = 1'b0;
            end else begin
              flags_q[pacs_pkg::FLAG_CARRY] = 1'b1;
            end
          end
          pacs_pkg::OP_SHIFT: begin
            if (n == 0 || n > 7) begin
              r.executed = 1'b0;
              stopped_q  = 1'b1;
              r.status   = pacs_pkg::ST_BAD_SH;
            end else if (sh > 0) begin
              flags_q[pacs_pkg::FLAG_CARRY] = a[n-1];
              acc_q = flags_q[pacs_pkg::FLAG_FILL] ? ~(na >> n) : (a >> n);
            end else begin
              flags_q[pacs_pkg::FLAG_CARRY] = a[8-n];
              acc_q = flags_q[pacs_pkg::FLAG_FILL] ? ~(na << n) : (a << n);
            end
          end
          pacs_pkg::OP_BIT0: flags_q[pacs_pkg::FLAG_CARRY] = a[0];
          pacs_pkg::OP_ROR: begin
            if (operand_q inside {[1:7]}) begin
              acc_q = (a >> operand_q) | (a << (8 - operand_q));
            end else begin
              r.executed = 1'b0;
              stopped_q  = 1'b1;
              r.status   = pacs_pkg::ST_BAD_SH;
            end
          end
          pacs_pkg::OP_ROR1:     acc_q = {a[0], a[pacs_pkg::DATA_W-1:1]};
          pacs_pkg::OP_CLR_HI:   flags_q[7:4] = '0;
          pacs_pkg::OP_CLR_CY:   flags_q[pacs_pkg::FLAG_CARRY] = 1'b0;
          pacs_pkg::OP_CLR_USR:  flags_q[pacs_pkg::FLAG_USER] = 1'b0;
          pacs_pkg::OP_CLR_FILL: flags_q[pacs_pkg::FLAG_FILL] = 1'b0;
          pacs_pkg::OP_TGL_PRED: flags_q[pacs_pkg::FLAG_PRED] = ~flags_q[pacs_pkg::FLAG_PRED];
          pacs_pkg::OP_SET_CY:   flags_q[pacs_pkg::FLAG_CARRY] = 1'b1;
          pacs_pkg::OP_SET_USR:  flags_q[pacs_pkg::FLAG_USER] = 1'b1;
          pacs_pkg::OP_SET_FILL: flags_q[pacs_pkg::FLAG_FILL] = 1'b1;
          default: begin
            r.executed = 1'b0;
            stopped_q  = 1'b1;
            r.status   = pacs_pkg::ST_ILLEGAL;
          end
        endcase
      end
    end
    r.next_fetch_address = {page_q, pc_q};
    r.accumulator_value  = acc_q;
    r.flag_value         = flags_q;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    pacs_pkg::result_t got;
    pacs_pkg::result_t want;
    if (!rst_n) begin
      acc_q     = '0;
      flags_q   = '0;
      pc_q      = '0;
      operand_q = '0;
      page_q    = '1;
      stopped_q = 1'b0;
      step_results_q.delete();
    end else begin
      // results first, so a result never meets the expectation pushed at the same edge
      if (out_tvalid && out_tready) begin
        got = pacs_pkg::result_t'(out_tdata[$bits(pacs_pkg::result_t)-1:0]);
        if (step_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result transaction with nothing expected, got %0h", $time, got);
        end else begin
          want = step_results_q.pop_front();
          check_field("next_fetch_address", want.next_fetch_address, got.next_fetch_address);
          check_field("accumulator_value", 16'(want.accumulator_value),
                      16'(got.accumulator_value));
          check_field("flag_value", 16'(want.flag_value), 16'(got.flag_value));
          check_field("out_valid", 16'(want.out_valid), 16'(got.out_valid));
          check_field("out_port", 16'(want.out_port), 16'(got.out_port));
          check_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
          check_field("executed", 16'(want.executed), 16'(got.executed));
          check_field("status", 16'(want.status), 16'(got.status));
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == pacs_pkg::CFG_OPERAND) operand_q = cfg_wdata;
        else page_q = cfg_wdata;
      end
      if (in_tvalid && in_tready)
        step_results_q.push_back(step_machine(
          pacs_pkg::item_t'(in_tdata[$bits(pacs_pkg::item_t)-1:0])));
    end
    pending_results = step_results_q.size();
  end

endmodule

// File: verif/tb_predicated_accumulator_cpu_step_core.sv
// stimulus and verdict for the accumulator step engine; checking lives in pacs_step_checker
module tb_predicated_accumulator_cpu_step_core;

  // illegal opcode range, low 7 bits
  localparam logic [pacs_pkg::OP_W-1:0] ILLEGAL_LO = 7'h10;
  localparam logic [pacs_pkg::OP_W-1:0] ILLEGAL_HI = 7'h7f;

  // receiver hold-off long enough to back the block up into its input
  localparam int HOLD_CYCLES = 300;

  localparam int PHASES     = 24;
  localparam int PHASE_ITEMS = 80;

  logic                             clk;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [pacs_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [pacs_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_wr_en  = 1'b0;
  logic                             cfg_index  = pacs_pkg::CFG_OPERAND;
  logic [pacs_pkg::DATA_W-1:0]      cfg_wdata  = '0;

  int fail_count;
  int pending_results;

  // random idling on both sides, cleared for a quiet stretch
  bit idle_on = 1'b0;
  // asks the receiver for one long hold-off
  bit hold_req = 1'b0;

  // predicate bit as the stimulus sees it, so that stopping codes stay unexecuted
  logic                        pred_flag = 1'b0;
  // operand register value last written, decides which shift/rotate amounts are safe
  logic [pacs_pkg::DATA_W-1:0] operand_cur = '0;

  // operand settings for the odd phases: small and large amounts both ways, both
  // output ports, and the signed extremes
  logic [pacs_pkg::DATA_W-1:0] operand_steps [0:11] =
    '{8'h01, 8'h02, 8'h03, 8'h07, 8'hff, 8'hfc, 8'hf9, 8'h7f, 8'h80, 8'h04, 8'hfe, 8'h05};

  predicated_accumulator_cpu_step_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  pacs_step_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard limit on the run
  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: random backpressure, plus one long counted hold-off on request
  initial begin : sink
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_req && held < HOLD_CYCLES) begin
        out_tready <= 1'b0;
        held++;
      end else begin
        out_tready <= !(idle_on && $urandom_range(0, 99) < 33);
      end
    end
  end

  // one register write, only called while nothing is in flight
  task automatic write_reg(logic idx, logic [pacs_pkg::DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == pacs_pkg::CFG_OPERAND) operand_cur = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // offer one instruction transaction; match picks bit 7 against the predicate
  task automatic send_op(logic [pacs_pkg::OP_W-1:0] op, bit match,
                         logic [pacs_pkg::DATA_W-1:0] port_byte, bit avail, bit accept);
    pacs_pkg::item_t it;
    it.instruction  = {(match ? pred_flag : ~pred_flag), op};
    it.in_byte      = port_byte;
    it.in_available = avail;
    it.in_accept    = accept;
    // only an executed toggle moves the predicate bit
    if (op == pacs_pkg::OP_TGL_PRED && match) pred_flag = ~pred_flag;
    if (idle_on && $urandom_range(0, 99) < 33) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pacs_pkg::IN_TDATA_W'(it);
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering and wait until every expected result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (2) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [pacs_pkg::OP_W-1:0] op;
    bit                        risky;
    int                        roll;
    int                        kind;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on = 1'b1;

    // directed: every opcode at least once, with port one selected and the low code page
    write_reg(pacs_pkg::CFG_OPERAND, pacs_pkg::PORT_ONE);
    write_reg(pacs_pkg::CFG_CODE_PAGE, 8'h00);
    send_op(pacs_pkg::OP_NOP, 1'b1, 8'hff, 1'b1, 1'b1);
    // input from a port other than zero clears the accumulator and sets carry
    send_op(pacs_pkg::OP_IN, 1'b1, 8'h5a, 1'b1, 1'b0);
    send_op(pacs_pkg::OP_OUT, 1'b1, 8'h00, 1'b0, 1'b1);
    // output refused by the sink
    send_op(pacs_pkg::OP_OUT, 1'b1, 8'h00, 1'b0, 1'b0);
    send_op(pacs_pkg::OP_SET_FILL, 1'b1, 8'h00, 1'b0, 1'b0);
    // right shift with ones fill
    send_op(pacs_pkg::OP_SHIFT, 1'b1, 8'h00, 1'b0, 1'b0);
    send_op(pacs_pkg::OP_ROR, 1'b1, 8'h00, 1'b0, 1'b0);
    send_op(pacs_pkg::OP_ROR1, 1'b1, 8'h00, 1'b0, 1'b0);
    send_op(pacs_pkg::OP_BIT0, 1'b1, 8'h00, 1'b0, 1'b0);
    send_op(pacs_pkg::OP_SET_USR, 1'b1, 8'h00, 1'b0, 1'b0);
    send_op(pacs_pkg::OP_SET_CY, 1'b1, 8'h00, 1'b0, 1'b0);
    send_op(pacs_pkg::OP_CLR_CY, 1'b1, 8'h00, 1'b0, 1'b0);
    send_op(pacs_pkg::OP_CLR_HI, 1'b1, 8'h00, 1'b0, 1'b0);
    send_op(pacs_pkg::OP_CLR_USR, 1'b1, 8'h00, 1'b0, 1'b0);
    send_op(pacs_pkg::OP_CLR_FILL, 1'b1, 8'h00, 1'b0, 1'b0);
    send_op(pacs_pkg::OP_TGL_PRED, 1'b1, 8'h00, 1'b0, 1'b0);
    // predicate now needs bit 7 high
    send_op(pacs_pkg::OP_NOP, 1'b1, 8'h00, 1'b0, 1'b0);
    // stopping codes with the predicate against them: just skipped
    send_op(pacs_pkg::OP_HALT, 1'b0, 8'h00, 1'b0, 1'b0);
    send_op(ILLEGAL_HI, 1'b0, 8'h00, 1'b0, 1'b0);
    send_op(pacs_pkg::OP_TGL_PRED, 1'b1, 8'h00, 1'b0, 1'b0);
    drain();

    // port zero input, then end of input, on the top code page
    write_reg(pacs_pkg::CFG_OPERAND, pacs_pkg::PORT_ZERO);
    write_reg(pacs_pkg::CFG_CODE_PAGE, 8'hff);
    send_op(pacs_pkg::OP_IN, 1'b1, 8'hff, 1'b1, 1'b0);
    send_op(pacs_pkg::OP_IN, 1'b1, 8'h00, 1'b0, 1'b0);
    // zero shift amount, but predicate mismatch keeps the machine running
    send_op(pacs_pkg::OP_SHIFT, 1'b0, 8'h00, 1'b0, 1'b0);
    drain();
    write_reg(pacs_pkg::CFG_OPERAND, pacs_pkg::PORT_TWO);
    send_op(pacs_pkg::OP_OUT, 1'b1, 8'h00, 1'b0, 1'b1);
    drain();
    // left shift by seven with ones fill
    write_reg(pacs_pkg::CFG_OPERAND, 8'hf9);
    send_op(pacs_pkg::OP_SET_FILL, 1'b1, 8'h00, 1'b0, 1'b0);
    send_op(pacs_pkg::OP_SHIFT, 1'b1, 8'h00, 1'b0, 1'b0);
    drain();

    // random phases; even phases read port zero to load fresh accumulator values
    for (int phase = 0; phase < PHASES; phase++) begin
      write_reg(pacs_pkg::CFG_OPERAND,
                (phase % 2 == 0) ? pacs_pkg::PORT_ZERO : operand_steps[phase / 2]);
      write_reg(pacs_pkg::CFG_CODE_PAGE, (phase == 0) ? 8'h00 :
                (phase == 1) ? 8'hff : pacs_pkg::DATA_W'($urandom_range(0, 255)));
      // quiet stretch with no idling on either side
      idle_on = !(phase == 9 || phase == 10);
      // long receiver hold-off while the sender keeps offering
      if (phase == 4) hold_req = 1'b1;
      repeat (PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 6) op = pacs_pkg::OP_W'($urandom_range(ILLEGAL_LO, ILLEGAL_HI));
        else op = pacs_pkg::OP_W'($urandom_range(pacs_pkg::OP_NOP, pacs_pkg::OP_SET_FILL));
        // anything that would stop the machine is sent with the predicate against it
        risky = (op == pacs_pkg::OP_HALT) || (op > pacs_pkg::OP_SET_FILL) ||
                (op == pacs_pkg::OP_SHIFT &&
                 !(operand_cur inside {[1:7]} || operand_cur >= 8'hf9)) ||
                (op == pacs_pkg::OP_ROR && !(operand_cur inside {[1:7]}));
        send_op(op, risky ? 1'b0 : ($urandom_range(0, 3) != 0),
                pacs_pkg::DATA_W'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      drain();
    end

    // stop the machine once: halt, illegal opcode or bad shift amount
    kind = $urandom_range(0, 2);
    if (kind == 0) begin
      op = pacs_pkg::OP_HALT;
    end else if (kind == 1) begin
      op = pacs_pkg::OP_W'($urandom_range(ILLEGAL_LO, ILLEGAL_HI));
    end else begin
      // zero amount is bad for both shift and rotate
      write_reg(pacs_pkg::CFG_OPERAND, 8'h00);
      op = $urandom_range(0, 1) ? pacs_pkg::OP_SHIFT : pacs_pkg::OP_ROR;
    end
    send_op(op, 1'b1, 8'h00, 1'b0, 1'b0);
    // stopped machine must ignore everything after
    repeat (12) begin
      send_op(pacs_pkg::OP_W'($urandom_range(pacs_pkg::OP_NOP, ILLEGAL_HI)),
              1'($urandom_range(0, 1)), pacs_pkg::DATA_W'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    drain();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/pacs_pkg.sv
design/predicated_accumulator_cpu_step.sv
verif/pacs_step_checker.sv
verif/tb_predicated_accumulator_cpu_step_core.sv
